FILE: rtl/quad_motor_speed_stepper_macros.svh
// Assertion macros shared by the quad motor speed stepper RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef QUAD_MOTOR_SPEED_STEPPER_MACROS_SVH
`define QUAD_MOTOR_SPEED_STEPPER_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define QMSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define QMSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define QMSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define QMSS_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define QMSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define QMSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/qmss_pkg.sv
// Shared types and constants of the quad motor speed stepper.
// No dependencies; every other RTL source file but the macros header imports this package.
package qmss_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_VALUE_W = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_SECONDS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_DEADBAND   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_LIMIT     = 2'd2;

    // Register reset values.
    localparam logic [7:0]  TIMEOUT_RESET  = 8'd1;
    localparam logic [14:0] DEADBAND_RESET = 15'd327;
    localparam logic [8:0]  STICK_RESET    = 9'd281;

    // Motor slots in the speed vector.
    localparam int MOTOR_ONE   = 0;
    localparam int MOTOR_TWO   = 1;
    localparam int MOTOR_THREE = 2;
    localparam int MOTOR_FOUR  = 3;
    localparam int MOTOR_COUNT = 4;

    localparam int DUTY_W = 7;

    // One control tick worth of sensor and stick data.
    typedef struct packed {
        logic signed [9:0]  throttle_step;
        logic signed [15:0] gyro_roll;
        logic signed [15:0] gyro_pitch;
        logic signed [15:0] gyro_yaw;
        logic [7:0]         command_age;
        logic [7:0]         mode_button;
    } qmss_sample_t;

    // Motor duties and the mode after one tick.
    typedef struct packed {
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_two;
        logic [DUTY_W-1:0] duty_three;
        logic [DUTY_W-1:0] duty_four;
        logic              stabilize_mode;
    } qmss_duty_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  timeout_seconds;
        logic [14:0] gyro_deadband;
        logic [8:0]  stick_limit;
    } qmss_cfg_t;

endpackage

FILE: rtl/qmss_if.sv
// Handshake interfaces of the quad motor speed stepper: sample, duty and config.
// Depends on qmss_pkg for the payload types.
interface qmss_sample_if
    import qmss_pkg::*;
();
    logic         valid;
    logic         ready;
    qmss_sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qmss_duty_if
    import qmss_pkg::*;
();
    logic       valid;
    logic       ready;
    qmss_duty_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qmss_cfg_if
    import qmss_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_VALUE_W-1:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

FILE: rtl/qmss_update.sv
// Next-state and duty logic for one control tick of the motor speed stepper.
// Purely combinational; depends on qmss_pkg.
module qmss_update
    import qmss_pkg::*;
#(
    parameter int FRACTION_BITS = 8,
    parameter int DUTY_RANGE    = 100,
    parameter int SPEED_W       = 15
)
(
    input  qmss_sample_t                            item,
    input  qmss_cfg_t                               cfg_regs,
    input  logic [MOTOR_COUNT-1:0][SPEED_W-1:0]     speed_cur,
    input  logic                                    mode_cur,
    input  logic [7:0]                              last_button_cur,
    output logic [MOTOR_COUNT-1:0][SPEED_W-1:0]     speed_next,
    output logic                                    mode_next,
    output qmss_duty_t                              result
);

    // Working width covers speeds, the raw step and the five point offset with headroom.
    localparam int BASE_A = (SPEED_W > 11) ? SPEED_W : 11;
    localparam int BASE_B = (BASE_A > FRACTION_BITS + 3) ? BASE_A : FRACTION_BITS + 3;
    localparam int WORK_W = BASE_B + 2;

    localparam logic signed [WORK_W-1:0] ONE_POINT  = WORK_W'(1 << FRACTION_BITS);
    localparam logic signed [WORK_W-1:0] MAX_OFFSET = WORK_W'(5 * (1 << FRACTION_BITS));
    localparam logic signed [WORK_W-1:0] STALE_STEP =
        WORK_W'(-(((1 << FRACTION_BITS) + 5) / 10));
    localparam logic signed [WORK_W-1:0] SPEED_MAX  =
        WORK_W'(DUTY_RANGE * (1 << FRACTION_BITS));

    // Magnitude of a raw gyro rate compared against the deadband.
    function automatic logic gyro_active(input logic signed [15:0] rate,
                                         input logic [14:0] deadband);
        logic [16:0] mag;
        mag = rate[15] ? (17'd0 - {rate[15], rate}) : {1'b0, rate};
        return mag > {2'b00, deadband};
    endfunction

    // Pair rule: bit 1 raises the low side, bit 0 raises the high side.
    function automatic logic [1:0] pair_nudge(input logic active, input logic neg,
                                              input logic signed [WORK_W-1:0] hi,
                                              input logic signed [WORK_W-1:0] lo);
        logic [1:0] r;
        r = 2'b00;
        if (active)
        begin
            if (neg && ((lo - hi) < MAX_OFFSET))
                r = 2'b10;
            else if ((hi - lo) < MAX_OFFSET)
                r = 2'b01;
        end
        return r;
    endfunction

    // Saturate a working value to the legal speed range.
    function automatic logic signed [WORK_W-1:0] clamp_speed(
            input logic signed [WORK_W-1:0] s);
        logic signed [WORK_W-1:0] r;
        if (s[WORK_W-1])
            r = '0;
        else if (s > SPEED_MAX)
            r = SPEED_MAX;
        else
            r = s;
        return r;
    endfunction

    logic signed [WORK_W-1:0] w [MOTOR_COUNT];
    logic signed [WORK_W-1:0] step;
    logic signed [WORK_W-1:0] step_mag;
    logic signed [WORK_W-1:0] limit_w;
    logic [1:0]               roll_nudge;
    logic [1:0]               pitch_nudge;
    logic                     yaw_on;

    // A rise in the button value toggles the mode before the speeds are updated.
    assign mode_next = mode_cur ^ (last_button_cur < item.mode_button);

    // Speed update for the selected mode.
    always_comb
    begin
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            w[i] = $signed(WORK_W'(speed_cur[i]));
        end

        step = WORK_W'(item.throttle_step);
        if (item.command_age > cfg_regs.timeout_seconds)
            step = STALE_STEP;
        step_mag = step[WORK_W-1] ? -step : step;
        limit_w  = $signed(WORK_W'(cfg_regs.stick_limit));

        roll_nudge  = pair_nudge(gyro_active(item.gyro_roll, cfg_regs.gyro_deadband),
                                 item.gyro_roll[15], w[MOTOR_ONE], w[MOTOR_THREE]);
        pitch_nudge = pair_nudge(gyro_active(item.gyro_pitch, cfg_regs.gyro_deadband),
                                 item.gyro_pitch[15], w[MOTOR_TWO], w[MOTOR_FOUR]);
        yaw_on      = gyro_active(item.gyro_yaw, cfg_regs.gyro_deadband);

        if (!mode_next)
        begin
            // Common throttle: motor three carries the shared speed.
            if (step_mag <= limit_w)
                w[MOTOR_THREE] = w[MOTOR_THREE] + step;
            w[MOTOR_THREE] = clamp_speed(w[MOTOR_THREE]);
            w[MOTOR_ONE]   = w[MOTOR_THREE];
            w[MOTOR_TWO]   = w[MOTOR_THREE];
            w[MOTOR_FOUR]  = w[MOTOR_THREE];
        end
        else
        begin
            // Tilt correction on the two motor pairs.
            if (roll_nudge[1])
                w[MOTOR_THREE] = w[MOTOR_THREE] + ONE_POINT;
            if (roll_nudge[0])
                w[MOTOR_ONE] = w[MOTOR_ONE] + ONE_POINT;
            if (pitch_nudge[1])
                w[MOTOR_FOUR] = w[MOTOR_FOUR] + ONE_POINT;
            if (pitch_nudge[0])
                w[MOTOR_TWO] = w[MOTOR_TWO] + ONE_POINT;

            // Yaw correction moves all motors one point against the rate.
            if (yaw_on)
            begin
                for (int i = 0; i < MOTOR_COUNT; i++)
                begin
                    w[i] = item.gyro_yaw[15] ? (w[i] + ONE_POINT) : (w[i] - ONE_POINT);
                end
            end
        end

        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            speed_next[i] = SPEED_W'(clamp_speed(w[i]));
        end
    end

    // Duties are the integer parts, kept to the duty field width.
    always_comb
    begin
        result.duty_one       = DUTY_W'(speed_next[MOTOR_ONE] >> FRACTION_BITS);
        result.duty_two       = DUTY_W'(speed_next[MOTOR_TWO] >> FRACTION_BITS);
        result.duty_three     = DUTY_W'(speed_next[MOTOR_THREE] >> FRACTION_BITS);
        result.duty_four      = DUTY_W'(speed_next[MOTOR_FOUR] >> FRACTION_BITS);
        result.stabilize_mode = mode_next;
    end

endmodule

FILE: rtl/quad_motor_speed_stepper.sv
// Quad motor speed stepper top level: input register, tick update, result register.
// An accepted sample passes the input register and then the result register to its duty transaction.
// Throughput is one sample per cycle while the duty output is ready; the single tick update between registers sets it.
// rst_n clears the speeds, the mode, the last button value and all valid flags, and
// loads the register defaults. Depends on qmss_pkg, qmss_if, qmss_update and the macros.
`include "quad_motor_speed_stepper_macros.svh"

module quad_motor_speed_stepper
    import qmss_pkg::*;
#(
    parameter int FRACTION_BITS = 8,
    parameter int DUTY_RANGE    = 100
)
(
    input  logic          clk,
    input  logic          rst_n,
    qmss_sample_if.sink   sample,
    qmss_duty_if.source   duty,
    qmss_cfg_if.sink      cfg
);

    localparam int SPEED_W = $clog2(DUTY_RANGE * (1 << FRACTION_BITS) + 1);
    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(DUTY_RANGE * (1 << FRACTION_BITS));

    qmss_cfg_t                           cfg_reg;
    logic                                in_valid_reg;
    qmss_sample_t                        in_item_reg;
    logic                                out_valid_reg;
    qmss_duty_t                          out_item_reg;
    logic [MOTOR_COUNT-1:0][SPEED_W-1:0] speed_reg;
    logic [MOTOR_COUNT-1:0][SPEED_W-1:0] speed_next;
    logic                                mode_reg;
    logic                                mode_next;
    logic [7:0]                          last_button_reg;
    qmss_duty_t                          result;
    logic                                advance;
    logic                                speeds_in_range;
    logic                                speeds_shared;

    // The tick stage moves forward when it holds a sample and the result register is free or drains.
    assign advance      = in_valid_reg && (!out_valid_reg || duty.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign duty.valid   = out_valid_reg;
    assign duty.data    = out_item_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_seconds <= TIMEOUT_RESET;
            cfg_reg.gyro_deadband   <= DEADBAND_RESET;
            cfg_reg.stick_limit     <= STICK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TIMEOUT_SECONDS: cfg_reg.timeout_seconds <= cfg.value[7:0];
                CFG_GYRO_DEADBAND:   cfg_reg.gyro_deadband   <= cfg.value[14:0];
                CFG_STICK_LIMIT:     cfg_reg.stick_limit     <= cfg.value[8:0];
                default:             ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.valid && sample.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            in_item_reg <= sample.data;
    end

    // One control tick of next-state logic.
    qmss_update #(
        .FRACTION_BITS (FRACTION_BITS),
        .DUTY_RANGE    (DUTY_RANGE),
        .SPEED_W       (SPEED_W)
    ) u_update (
        .item            (in_item_reg),
        .cfg_regs        (cfg_reg),
        .speed_cur       (speed_reg),
        .mode_cur        (mode_reg),
        .last_button_cur (last_button_reg),
        .speed_next      (speed_next),
        .mode_next       (mode_next),
        .result          (result)
    );

    // Tick state commits when the stage advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg       <= '0;
            mode_reg        <= 1'b0;
            last_button_reg <= '0;
        end
        else if (advance)
        begin
            speed_reg       <= speed_next;
            mode_reg        <= mode_next;
            last_button_reg <= in_item_reg.mode_button;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (duty.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= result;
    end

    // Summary conditions on the stored speeds for the checks below.
    assign speeds_in_range = (speed_reg[MOTOR_ONE] <= SPEED_MAX) &&
                             (speed_reg[MOTOR_TWO] <= SPEED_MAX) &&
                             (speed_reg[MOTOR_THREE] <= SPEED_MAX) &&
                             (speed_reg[MOTOR_FOUR] <= SPEED_MAX);
    assign speeds_shared   = (speed_reg[MOTOR_ONE] == speed_reg[MOTOR_THREE]) &&
                             (speed_reg[MOTOR_TWO] == speed_reg[MOTOR_THREE]) &&
                             (speed_reg[MOTOR_FOUR] == speed_reg[MOTOR_THREE]);

    // Stored speeds stay inside the saturation range.
    `QMSS_ASSERT_ALWAYS(a_speed_range, clk, rst_n, speeds_in_range, "speed out of range")

    // In common throttle mode all four motors share one speed.
    `QMSS_ASSERT_IMPL(a_common_speed, clk, rst_n, !mode_reg, speeds_shared, "motor speeds differ")

    // The mode changes only when a tick is processed.
    `QMSS_ASSERT_NEXT(a_mode_hold, clk, rst_n, !advance, $stable(mode_reg), "mode changed")

    // A new result appears only after a held sample.
    `QMSS_ASSERT_IMPL(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(in_valid_reg), "no sample")

endmodule

FILE: dv/tb_quad_motor_speed_stepper.sv
// Self-checking testbench for quad_motor_speed_stepper: directed ticks, then random flight
// sequences under several register settings, each duty transaction checked against a model.
// Depends on qmss_pkg, the qmss_if interfaces and the quad_motor_speed_stepper RTL.
module tb_quad_motor_speed_stepper;
    import qmss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRACTION_BITS  = 8;
    localparam int DUTY_RANGE     = 100;
    localparam int ONE_POINT      = 1 << FRACTION_BITS;
    localparam int MAX_OFFSET     = 5 * ONE_POINT;
    localparam int STALE_STEP     = -((ONE_POINT + 5) / 10);
    localparam int SPEED_MAX      = DUTY_RANGE * ONE_POINT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Index with no register behind it; the block ignores writes to it.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Local drivers of the channel inputs, known from time zero.
    logic                   smp_valid = 1'b0;
    qmss_sample_t           smp_data  = '0;
    logic                   duty_rdy  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_VALUE_W-1:0] cfg_value = '0;

    qmss_sample_if sample_ch ();
    qmss_duty_if   duty_ch ();
    qmss_cfg_if    cfg_ch ();

    assign sample_ch.valid = smp_valid;
    assign sample_ch.data  = smp_data;
    assign duty_ch.ready   = duty_rdy;
    assign cfg_ch.valid    = cfg_valid;
    assign cfg_ch.index    = cfg_index;
    assign cfg_ch.value    = cfg_value;

    quad_motor_speed_stepper #(
        .FRACTION_BITS(FRACTION_BITS),
        .DUTY_RANGE   (DUTY_RANGE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .duty  (duty_ch),
        .cfg   (cfg_ch)
    );

    // Shadow registers and motor state of the duty model.
    logic [7:0]  timeout_reg  = TIMEOUT_RESET;
    logic [14:0] deadband_reg = DEADBAND_RESET;
    logic [8:0]  stick_reg    = STICK_RESET;
    int          motor_speed [MOTOR_COUNT];
    logic        model_mode   = 1'b0;
    logic [7:0]  model_button = 8'd0;

    qmss_sample_t sample_queue [$];
    qmss_duty_t   duty_expect [$];

    // Generator bookkeeping: button and mode as the queued samples will leave them.
    logic [7:0] gen_button = 8'd0;
    logic       gen_mode   = 1'b0;
    int         items_made = 0;

    logic calm = 1'b0;
    logic smp_fire = 1'b0;
    int   send_gap = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   error_count = 0;

    // Clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_speed(int s);
        if (s < 0)
            return 0;
        if (s > SPEED_MAX)
            return SPEED_MAX;
        return s;
    endfunction

    // One motor pair: the low side rises on a negative rate, else the high side rises.
    function automatic void nudge_pair(int rate, int hi, int lo);
        if (magnitude(rate) > int'(deadband_reg))
        begin
            if (rate < 0 && (motor_speed[lo] - motor_speed[hi]) < MAX_OFFSET)
                motor_speed[lo] += ONE_POINT;
            else if ((motor_speed[hi] - motor_speed[lo]) < MAX_OFFSET)
                motor_speed[hi] += ONE_POINT;
        end
    endfunction

    // Advances the motor model by one control tick and returns the duties it yields.
    function automatic qmss_duty_t compute_duties(qmss_sample_t s);
        int         step;
        int         yaw;
        int         delta;
        qmss_duty_t r;
        step = int'($signed(s.throttle_step));
        yaw  = int'($signed(s.gyro_yaw));
        if (s.command_age > timeout_reg)
            step = STALE_STEP;
        if (model_button < s.mode_button)
            model_mode = ~model_mode;
        model_button = s.mode_button;
        if (!model_mode)
        begin
            if (magnitude(step) <= int'(stick_reg))
                motor_speed[MOTOR_THREE] += step;
            motor_speed[MOTOR_THREE] = clamp_speed(motor_speed[MOTOR_THREE]);
            motor_speed[MOTOR_ONE]   = motor_speed[MOTOR_THREE];
            motor_speed[MOTOR_TWO]   = motor_speed[MOTOR_THREE];
            motor_speed[MOTOR_FOUR]  = motor_speed[MOTOR_THREE];
        end
        else
        begin
            nudge_pair(int'($signed(s.gyro_roll)), MOTOR_ONE, MOTOR_THREE);
            nudge_pair(int'($signed(s.gyro_pitch)), MOTOR_TWO, MOTOR_FOUR);
            if (magnitude(yaw) > int'(deadband_reg))
            begin
                delta = (yaw > int'(deadband_reg)) ? -ONE_POINT : ONE_POINT;
                for (int m = 0; m < MOTOR_COUNT; m++)
                    motor_speed[m] += delta;
            end
        end
        for (int m = 0; m < MOTOR_COUNT; m++)
            motor_speed[m] = clamp_speed(motor_speed[m]);
        r.duty_one       = DUTY_W'(motor_speed[MOTOR_ONE] >> FRACTION_BITS);
        r.duty_two       = DUTY_W'(motor_speed[MOTOR_TWO] >> FRACTION_BITS);
        r.duty_three     = DUTY_W'(motor_speed[MOTOR_THREE] >> FRACTION_BITS);
        r.duty_four      = DUTY_W'(motor_speed[MOTOR_FOUR] >> FRACTION_BITS);
        r.stabilize_mode = model_mode;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Sample driver: holds a transaction until it is taken, inserts random idle bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            smp_valid <= 1'b0;
        end
        else if (!smp_valid || smp_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                smp_valid <= 1'b0;
            end
            else if (sample_queue.size() == 0)
            begin
                smp_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 10);
                smp_valid <= 1'b0;
            end
            else
            begin
                smp_data  <= sample_queue.pop_front();
                smp_valid <= 1'b1;
            end
        end
    end

    // Duty receiver: ready with random stall bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            duty_rdy <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            duty_rdy <= 1'b0;
        end
        else
        begin
            duty_rdy <= 1'b1;
        end
    end

    // Monitor: predicts on each sample transaction, checks each duty transaction.
    always @(posedge clk)
    begin
        qmss_duty_t want;
        logic       cfg_fire;
        logic       duty_fire;
        smp_fire  = rst_n && smp_valid && sample_ch.ready;
        cfg_fire  = rst_n && cfg_valid && cfg_ch.ready;
        duty_fire = rst_n && duty_ch.valid && duty_rdy;
        if (smp_fire)
            duty_expect.push_back(compute_duties(smp_data));
        if (duty_fire)
        begin
            if (duty_expect.size() == 0)
            begin
                $display("%0t ns: duty transaction with nothing expected, actual %h",
                         $time, duty_ch.data);
                error_count++;
            end
            else
            begin
                want = duty_expect.pop_front();
                check_field("duty_one", int'(want.duty_one), int'(duty_ch.data.duty_one));
                check_field("duty_two", int'(want.duty_two), int'(duty_ch.data.duty_two));
                check_field("duty_three", int'(want.duty_three),
                            int'(duty_ch.data.duty_three));
                check_field("duty_four", int'(want.duty_four), int'(duty_ch.data.duty_four));
                check_field("stabilize_mode", int'(want.stabilize_mode),
                            int'(duty_ch.data.stabilize_mode));
            end
        end
        if (!rst_n || smp_fire || cfg_fire || duty_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Register write; the model's shadow copy changes when the transaction completes.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_VALUE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_value = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_TIMEOUT_SECONDS: timeout_reg  = val[7:0];
            CFG_GYRO_DEADBAND:   deadband_reg = val[14:0];
            CFG_STICK_LIMIT:     stick_reg    = val[8:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Waits until every queued sample is taken and every duty has come back.
    task automatic wait_drained();
        while (sample_queue.size() != 0 || smp_valid || duty_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_sample(int step, int roll, int pitch, int yaw, int age, int btn);
        qmss_sample_t s;
        s.throttle_step = 10'(step);
        s.gyro_roll     = 16'(roll);
        s.gyro_pitch    = 16'(pitch);
        s.gyro_yaw      = 16'(yaw);
        s.command_age   = 8'(age);
        s.mode_button   = 8'(btn);
        if (s.mode_button > gen_button)
            gen_mode = ~gen_mode;
        gen_button = s.mode_button;
        sample_queue.push_back(s);
        items_made++;
    endtask

    function automatic int rand_gyro();
        logic [15:0] v;
        v = 16'($urandom);
        return int'($signed(v));
    endfunction

    function automatic int rand_step();
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    // Gyro rate for stabilize sequences: full range, deadband edges and full scale.
    function automatic int stab_rate();
        int sgn;
        sgn = $urandom_range(0, 1) ? -1 : 1;
        case ($urandom_range(0, 4))
            0, 1: return rand_gyro();
            2: return sgn * (int'(deadband_reg) + 1);
            3: return sgn * int'(deadband_reg);
            default: return sgn < 0 ? -32768 : 32767;
        endcase
    endfunction

    function automatic int fresh_age();
        return $urandom_range(0, timeout_reg);
    endfunction

    function automatic int stale_age();
        if (timeout_reg == 8'd255)
            return 255;
        return $urandom_range(int'(timeout_reg) + 1, 255);
    endfunction

    // Flips the mode with a button rise, dropping the button first when it is at the top.
    task automatic toggle_mode();
        if (gen_button == 8'd255)
            push_sample(rand_step(), rand_gyro(), rand_gyro(), rand_gyro(), fresh_age(), 0);
        push_sample(rand_step(), rand_gyro(), rand_gyro(), rand_gyro(), fresh_age(),
                    $urandom_range(int'(gen_button) + 1, 255));
    endtask

    // Random flight: climbs, descents, stale links, stabilize runs and plain noise.
    task automatic run_random(int count);
        int target;
        int len;
        target = items_made + count;
        while (items_made < target)
        begin
            len = $urandom_range(3, 25);
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    if (gen_mode)
                        toggle_mode();
                    repeat (len)
                        push_sample($urandom_range(int'(stick_reg) / 2, stick_reg),
                                    rand_gyro(), rand_gyro(), rand_gyro(), fresh_age(),
                                    gen_button);
                end
                3, 4:
                begin
                    if (gen_mode)
                        toggle_mode();
                    repeat (len)
                        push_sample(-int'($urandom_range(int'(stick_reg) / 2, stick_reg)),
                                    rand_gyro(), rand_gyro(), rand_gyro(), fresh_age(),
                                    gen_button);
                end
                5:
                begin
                    repeat (len)
                        push_sample(rand_step(), rand_gyro(), rand_gyro(), rand_gyro(),
                                    $urandom_range(0, 1) ? stale_age() : fresh_age(),
                                    gen_button);
                end
                6, 7, 8:
                begin
                    if (!gen_mode)
                        toggle_mode();
                    repeat (len)
                        push_sample(rand_step(), stab_rate(), stab_rate(), stab_rate(),
                                    $urandom_range(0, 255),
                                    $urandom_range(0, 3) == 0 ?
                                        $urandom_range(0, gen_button) : gen_button);
                end
                default:
                begin
                    repeat (len)
                        push_sample(rand_step(), rand_gyro(), rand_gyro(), rand_gyro(),
                                    $urandom_range(0, 255), $urandom_range(0, 255));
                end
            endcase
        end
    endtask

    // Test sequence.
    initial
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
            motor_speed[m] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks under the reset register values.
        push_sample(0, 0, 0, 0, 0, 0);
        push_sample(281, 32767, -32768, 32767, 0, 0);
        push_sample(282, -32768, 32767, -32768, 0, 0);
        push_sample(511, 0, 0, 0, 0, 0);
        push_sample(-512, 0, 0, 0, 0, 0);
        push_sample(-281, 0, 0, 0, 0, 0);
        push_sample(-100, 0, 0, 0, 0, 0);
        push_sample(200, 0, 0, 0, 1, 0);
        push_sample(200, 0, 0, 0, 2, 0);
        push_sample(0, 0, 0, 0, 255, 0);
        push_sample(0, 0, 0, 0, 0, 7);
        // Roll low and pitch high up to the pair offset limit and one past it.
        repeat (6) push_sample(0, -32768, 32767, 0, 0, 7);
        push_sample(0, 327, -327, 327, 0, 7);
        push_sample(0, 328, -328, 328, 0, 7);
        push_sample(0, 0, 0, -32768, 0, 3);
        push_sample(0, 0, 0, -328, 0, 3);
        push_sample(100, 0, 0, 0, 0, 255);
        push_sample(0, 0, 0, 0, 0, 0);
        push_sample(0, 0, 0, 0, 0, 1);
        repeat (3) push_sample(0, 0, 0, 32767, 0, 1);
        wait_drained();

        // Loose extremes: never fresh beyond age zero, no deadband, widest stick.
        write_reg(CFG_TIMEOUT_SECONDS, 15'd0);
        write_reg(CFG_GYRO_DEADBAND, 15'd0);
        write_reg(CFG_STICK_LIMIT, 15'd511);
        run_random(150);
        wait_drained();

        // Tight extremes: never stale, widest deadband, stick fully blocked.
        write_reg(CFG_TIMEOUT_SECONDS, 15'd255);
        write_reg(CFG_GYRO_DEADBAND, 15'd32767);
        write_reg(CFG_STICK_LIMIT, 15'd0);
        run_random(100);
        wait_drained();

        // Random settings, full-width values for the timeout and stick limit, plus the unused index.
        write_reg(CFG_TIMEOUT_SECONDS, CFG_VALUE_W'($urandom));
        write_reg(CFG_GYRO_DEADBAND, CFG_VALUE_W'($urandom_range(0, 4000)));
        write_reg(CFG_STICK_LIMIT, CFG_VALUE_W'($urandom));
        write_reg(CFG_UNUSED_INDEX, CFG_VALUE_W'($urandom));
        run_random(100);
        // Sender holds off until the pipeline is empty.
        wait_drained();
        run_random(100);
        wait_drained();

        // Back to the default settings, with no idling on either side.
        write_reg(CFG_TIMEOUT_SECONDS, 15'(TIMEOUT_RESET));
        write_reg(CFG_GYRO_DEADBAND, 15'(DEADBAND_RESET));
        write_reg(CFG_STICK_LIMIT, 15'(STICK_RESET));
        calm = 1'b1;
        run_random(150);
        wait_drained();

        if (error_count == 0 && duty_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/qmss_pkg.sv
rtl/qmss_if.sv
rtl/qmss_update.sv
rtl/quad_motor_speed_stepper.sv
dv/tb_quad_motor_speed_stepper.sv
